// ----- design/vt52ecd_pkg.sv -----
// ----------------------------------------------------------------------------
// VT52 escape decoder package
// Shared types, command codes and helpers for the escape command decoder.
// ----------------------------------------------------------------------------
package vt52ecd_pkg;

    // Register defaults and queue sizing
    localparam logic [7:0] MAX_COL_RESET     = 8'd79;
    localparam logic [5:0] MAX_ROW_RESET     = 6'd24;
    localparam int         DEF_QUEUE_DEPTH   = 4;

    // Configuration register indexes
    localparam logic CFG_MAX_COL = 1'b0;
    localparam logic CFG_MAX_ROW = 1'b1;

    // Parameter byte bias of direct addressing
    localparam logic [7:0] PARAM_OFFSET = 8'd32;

    // Command letters
    localparam logic [7:0] CH_UP      = 8'h41; // A
    localparam logic [7:0] CH_DOWN    = 8'h42; // B
    localparam logic [7:0] CH_RIGHT   = 8'h43; // C
    localparam logic [7:0] CH_LEFT    = 8'h44; // D
    localparam logic [7:0] CH_CLEAR   = 8'h45; // E
    localparam logic [7:0] CH_HOME    = 8'h48; // H
    localparam logic [7:0] CH_RUP     = 8'h49; // I
    localparam logic [7:0] CH_CLR_EOS = 8'h4A; // J
    localparam logic [7:0] CH_CLR_EOL = 8'h4B; // K
    localparam logic [7:0] CH_INS     = 8'h4C; // L
    localparam logic [7:0] CH_DEL     = 8'h4D; // M
    localparam logic [7:0] CH_ADDR    = 8'h59; // Y
    localparam logic [7:0] CH_CLR_BOS = 8'h64; // d
    localparam logic [7:0] CH_SHOW    = 8'h65; // e
    localparam logic [7:0] CH_HIDE    = 8'h66; // f
    localparam logic [7:0] CH_SAVE    = 8'h6A; // j
    localparam logic [7:0] CH_RESTORE = 8'h6B; // k
    localparam logic [7:0] CH_CLR_LN  = 8'h6C; // l
    localparam logic [7:0] CH_CLR_BOL = 8'h6F; // o
    localparam logic [7:0] CH_REV_ON  = 8'h70; // p
    localparam logic [7:0] CH_REV_OFF = 8'h71; // q
    localparam logic [7:0] CH_WRAP_ON = 8'h76; // v
    localparam logic [7:0] CH_WRAP_OFF= 8'h77; // w

    typedef enum logic [2:0] {
        ACT_NONE        = 3'd0,
        ACT_CLEAR       = 3'd1,
        ACT_CLR_LINES   = 3'd2,
        ACT_ERASE_END   = 3'd3,
        ACT_ERASE_START = 3'd4,
        ACT_SCROLL_DOWN = 3'd5,
        ACT_INSERT      = 3'd6,
        ACT_DELETE      = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        PH_CMD = 2'd0,
        PH_ROW = 2'd1,
        PH_COL = 2'd2
    } t_phase;

    // One screen action
    typedef struct packed {
        logic [7:0] column;
        logic [5:0] last_line;
        logic [5:0] first_line;
        t_action    action;
    } t_act;

    // Everything one input byte produces
    typedef struct packed {
        logic       wrap_flag;
        logic       reverse_flag;
        logic       visible_flag;
        logic [5:0] new_row;
        logic [7:0] new_col;
        logic       two;
        t_act       act1;
        t_act       act0;
    } t_cmd;

    // One result item, action in the low bits
    typedef struct packed {
        logic       wrap_flag;
        logic       reverse_flag;
        logic       visible_flag;
        logic [5:0] new_row;
        logic [7:0] new_col;
        t_act       act;
    } t_result;

    localparam t_act ACT_IDLE = '{column: 8'd0, last_line: 6'd0, first_line: 6'd0,
                                  action: ACT_NONE};

    // Unbias a parameter byte, force negatives to zero, clamp to limit
    function automatic logic [7:0] param_value(input logic [7:0] b, input logic [7:0] limit);
        logic [7:0] v;
        v = b - PARAM_OFFSET;
        if (v[7]) begin
            v = 8'd0;
        end
        return (v < limit) ? v : limit;
    endfunction

endpackage

// ----- design/vt52ecd_front.sv -----
// ----------------------------------------------------------------------------
// VT52 escape decoder front end
// Accepts bytes, keeps the escape state and turns each byte into a command.
// ----------------------------------------------------------------------------
module vt52ecd_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [7:0]            i_code_byte,
    input  logic [7:0]            i_cur_col,
    input  logic [5:0]            i_cur_row,
    input  logic [7:0]            i_max_col,
    input  logic [5:0]            i_max_row,
    input  logic                  i_full,
    output logic                  o_push,
    output vt52ecd_pkg::t_cmd     o_cmd
);

    vt52ecd_pkg::t_phase r_phase, n_phase;
    logic [5:0] r_pending_row, n_pending_row;
    logic [7:0] r_saved_col, n_saved_col;
    logic [5:0] r_saved_row, n_saved_row;
    logic       r_shown, n_shown;
    logic       r_reverse, n_reverse;
    logic       r_wrap, n_wrap;

    logic [7:0] x, y8, row_param, col_param;
    logic [5:0] y;
    vt52ecd_pkg::t_act a0, a1;
    logic       two;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= vt52ecd_pkg::PH_CMD;
            r_pending_row <= '0;
            r_saved_col   <= '0;
            r_saved_row   <= '0;
            r_shown       <= 1'b0;
            r_reverse     <= 1'b0;
            r_wrap        <= 1'b0;
        end else if (o_push) begin
            r_phase       <= n_phase;
            r_pending_row <= n_pending_row;
            r_saved_col   <= n_saved_col;
            r_saved_row   <= n_saved_row;
            r_shown       <= n_shown;
            r_reverse     <= n_reverse;
            r_wrap        <= n_wrap;
        end
    end

    always_comb begin
        row_param = vt52ecd_pkg::param_value(i_code_byte, {2'b00, i_max_row});
        col_param = vt52ecd_pkg::param_value(i_code_byte, i_max_col);
        y8        = 8'd0;
        x             = i_cur_col;
        y             = i_cur_row;
        a0            = vt52ecd_pkg::ACT_IDLE;
        a1            = vt52ecd_pkg::ACT_IDLE;
        two           = 1'b0;
        n_phase       = vt52ecd_pkg::PH_CMD;
        n_pending_row = r_pending_row;
        n_saved_col   = r_saved_col;
        n_saved_row   = r_saved_row;
        n_shown       = r_shown;
        n_reverse     = r_reverse;
        n_wrap        = r_wrap;
        unique case (r_phase)
            vt52ecd_pkg::PH_ROW: begin
                n_pending_row = row_param[5:0];
                n_phase       = vt52ecd_pkg::PH_COL;
            end
            vt52ecd_pkg::PH_COL: begin
                x = col_param;
                y = r_pending_row;
            end
            default: begin
                unique case (i_code_byte)
                    vt52ecd_pkg::CH_UP: begin
                        if (y != 6'd0) y = y - 6'd1;
                    end
                    vt52ecd_pkg::CH_DOWN: begin
                        if (y < i_max_row) y = y + 6'd1;
                    end
                    vt52ecd_pkg::CH_RIGHT: begin
                        if (x < i_max_col) x = x + 8'd1;
                    end
                    vt52ecd_pkg::CH_LEFT: begin
                        if (x != 8'd0) x = x - 8'd1;
                    end
                    vt52ecd_pkg::CH_CLEAR: begin
                        a0.action = vt52ecd_pkg::ACT_CLEAR;
                        x = 8'd0;
                        y = 6'd0;
                    end
                    vt52ecd_pkg::CH_HOME: begin
                        x = 8'd0;
                        y = 6'd0;
                    end
                    vt52ecd_pkg::CH_RUP: begin
                        if (y != 6'd0) begin
                            y = y - 6'd1;
                        end else begin
                            a0.action    = vt52ecd_pkg::ACT_SCROLL_DOWN;
                            a0.last_line = i_max_row;
                        end
                    end
                    vt52ecd_pkg::CH_CLR_EOS: begin
                        if (y < i_max_row) begin
                            a0.action     = vt52ecd_pkg::ACT_CLR_LINES;
                            a0.first_line = y + 6'd1;
                            a0.last_line  = i_max_row;
                            a1.action     = vt52ecd_pkg::ACT_ERASE_END;
                            a1.first_line = y;
                            a1.column     = x;
                            two           = 1'b1;
                        end else begin
                            a0.action     = vt52ecd_pkg::ACT_ERASE_END;
                            a0.first_line = y;
                            a0.column     = x;
                        end
                    end
                    vt52ecd_pkg::CH_CLR_EOL: begin
                        a0.action     = vt52ecd_pkg::ACT_ERASE_END;
                        a0.first_line = y;
                        a0.column     = x;
                    end
                    vt52ecd_pkg::CH_INS, vt52ecd_pkg::CH_DEL: begin
                        a0.first_line = y;
                        if (y >= i_max_row) begin
                            a0.action    = vt52ecd_pkg::ACT_CLR_LINES;
                            a0.last_line = y;
                        end else begin
                            a0.action    = (i_code_byte == vt52ecd_pkg::CH_DEL) ?
                                           vt52ecd_pkg::ACT_DELETE : vt52ecd_pkg::ACT_INSERT;
                            a0.last_line = i_max_row;
                        end
                        x = 8'd0;
                    end
                    vt52ecd_pkg::CH_ADDR: begin
                        n_phase = vt52ecd_pkg::PH_ROW;
                    end
                    vt52ecd_pkg::CH_CLR_BOS: begin
                        // clear rows above, then line start before the cursor
                        if (y != 6'd0 && x != 8'd0) begin
                            a0.action     = vt52ecd_pkg::ACT_CLR_LINES;
                            a0.last_line  = y - 6'd1;
                            a1.action     = vt52ecd_pkg::ACT_ERASE_START;
                            a1.first_line = y;
                            a1.column     = x - 8'd1;
                            two           = 1'b1;
                        end else if (y != 6'd0) begin
                            a0.action     = vt52ecd_pkg::ACT_CLR_LINES;
                            a0.last_line  = y - 6'd1;
                        end else if (x != 8'd0) begin
                            a0.action     = vt52ecd_pkg::ACT_ERASE_START;
                            a0.first_line = y;
                            a0.column     = x - 8'd1;
                        end
                    end
                    vt52ecd_pkg::CH_SHOW:     n_shown   = 1'b1;
                    vt52ecd_pkg::CH_HIDE:     n_shown   = 1'b0;
                    vt52ecd_pkg::CH_SAVE: begin
                        n_saved_col = x;
                        n_saved_row = y;
                    end
                    vt52ecd_pkg::CH_RESTORE: begin
                        x = r_saved_col;
                        y = r_saved_row;
                    end
                    vt52ecd_pkg::CH_CLR_LN: begin
                        a0.action     = vt52ecd_pkg::ACT_CLR_LINES;
                        a0.first_line = y;
                        a0.last_line  = y;
                        x = 8'd0;
                    end
                    vt52ecd_pkg::CH_CLR_BOL: begin
                        a0.action     = vt52ecd_pkg::ACT_ERASE_START;
                        a0.first_line = y;
                        a0.column     = x;
                    end
                    vt52ecd_pkg::CH_REV_ON:   n_reverse = 1'b1;
                    vt52ecd_pkg::CH_REV_OFF:  n_reverse = 1'b0;
                    vt52ecd_pkg::CH_WRAP_ON:  n_wrap    = 1'b1;
                    vt52ecd_pkg::CH_WRAP_OFF: n_wrap    = 1'b0;
                    default: y8 = 8'd0; // unknown command: no effect
                endcase
            end
        endcase
        o_cmd.act0         = a0;
        o_cmd.act1         = a1;
        o_cmd.two          = two;
        o_cmd.new_col      = x;
        o_cmd.new_row      = y | y8[5:0];
        o_cmd.visible_flag = n_shown;
        o_cmd.reverse_flag = n_reverse;
        o_cmd.wrap_flag    = n_wrap;
    end

endmodule

// ----- design/vt52ecd_queue.sv -----
// ----------------------------------------------------------------------------
// VT52 escape decoder command queue
// Small FIFO of decoded commands between the front and back ends.
// ----------------------------------------------------------------------------
module vt52ecd_queue #(
    parameter int DEPTH = vt52ecd_pkg::DEF_QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  vt52ecd_pkg::t_cmd i_cmd,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output vt52ecd_pkg::t_cmd o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    vt52ecd_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ----- design/vt52ecd_back.sv -----
// ----------------------------------------------------------------------------
// VT52 escape decoder back end
// Splits each queued command into its results and holds them for the sink.
// ----------------------------------------------------------------------------
module vt52ecd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_head_valid,
    input  vt52ecd_pkg::t_cmd    i_head,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output vt52ecd_pkg::t_result o_result,
    output logic                 o_last
);

    logic                 r_valid, n_valid;
    logic                 r_sel, n_sel;
    vt52ecd_pkg::t_result r_result, n_result;
    logic                 r_last, n_last;
    logic                 load;

    assign o_valid  = r_valid;
    assign o_result = r_result;
    assign o_last   = r_last;

    always_comb begin
        load     = !r_valid || i_ready;
        n_valid  = load ? i_head_valid : r_valid;
        n_sel    = r_sel;
        n_last   = r_sel || !i_head.two;
        o_pop    = load && i_head_valid && n_last;
        if (load && i_head_valid) begin
            n_sel = i_head.two && !r_sel;
        end
        n_result.act          = r_sel ? i_head.act1 : i_head.act0;
        n_result.new_col      = i_head.new_col;
        n_result.new_row      = i_head.new_row;
        n_result.visible_flag = i_head.visible_flag;
        n_result.reverse_flag = i_head.reverse_flag;
        n_result.wrap_flag    = i_head.wrap_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sel   <= n_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_head_valid) begin
            r_result <= n_result;
            r_last   <= n_last;
        end
    end

endmodule

// ----- design/vt52_escape_command_decoder.sv -----
// ----------------------------------------------------------------------------
// VT52 escape command decoder
// Decodes the bytes after ESC into cursor moves, flags and screen actions.
// ----------------------------------------------------------------------------
// Takes one byte per cycle on the slave stream while the command queue has
// room, each with the cursor the text engine holds, and gives one result (two
// for J and d when both parts apply) on the master stream; tlast marks the
// final result of a byte. A byte is decoded in the cycle it is accepted and
// lands in a small command queue; the back end loads its results from the
// queue head into the output register and drains one result per cycle from
// it while the sink is ready. Sustained rate is one byte per cycle while the
// sink keeps up, limited by the output at one result per cycle when two-result
// commands come in. The queue depth (QUEUE_DEPTH) sets how many bytes can be
// taken while the sink stalls. Write max_col and max_row only while idle.
// ----------------------------------------------------------------------------
module vt52_escape_command_decoder #(
    parameter int QUEUE_DEPTH = vt52ecd_pkg::DEF_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // byte stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // code_byte[7:0], cur_col[15:8], cur_row[21:16], zero
    // result stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // action[2:0], first_line[8:3], last_line[14:9],
                                       // column[22:15], new_col[30:23], new_row[36:31],
                                       // visible_flag[37], reverse_flag[38], wrap_flag[39]
    output logic        m_axis_tlast   // last
);

    logic [7:0] r_max_col;
    logic [5:0] r_max_row;

    logic                 push, full, pop, head_valid;
    vt52ecd_pkg::t_cmd    cmd, head;
    vt52ecd_pkg::t_result result;

    // Hold the screen limits; the user must write them only between bytes, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_col <= vt52ecd_pkg::MAX_COL_RESET;
            r_max_row <= vt52ecd_pkg::MAX_ROW_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == vt52ecd_pkg::CFG_MAX_COL) begin
                r_max_col <= i_cfg_data;
            end else begin
                r_max_row <= i_cfg_data[5:0];
            end
        end
    end

    // Front: decode the byte and advance the escape state
    vt52ecd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_code_byte (s_axis_tdata[7:0]),
        .i_cur_col   (s_axis_tdata[15:8]),
        .i_cur_row   (s_axis_tdata[21:16]),
        .i_max_col   (r_max_col),
        .i_max_row   (r_max_row),
        .i_full      (full),
        .o_push      (push),
        .o_cmd       (cmd)
    );

    // Queue: decouple decode from the result stream
    vt52ecd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_head  (head)
    );

    // Back: emit one result per transfer
    vt52ecd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_result     (result),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tdata = result;

endmodule

// ----- design/vt52ecd_checker.sv -----
// ----------------------------------------------------------------------------
// VT52 escape decoder port checker
// Watches the result stream of the decoder for rule breaks.
// ----------------------------------------------------------------------------
module vt52ecd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // No result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // A no-op result carries zero line and column fields
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] == vt52ecd_pkg::ACT_NONE |->
            m_axis_tdata[22:3] == 20'd0)
        else $error("no-op result with nonzero fields");

    // Only a line clear opens a two-result byte
    a_first_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |->
            m_axis_tdata[2:0] == vt52ecd_pkg::ACT_CLR_LINES)
        else $error("unexpected first result of a pair");

    // The second result follows at once with the same cursor and flags
    a_pair_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && $stable(m_axis_tdata[39:23]))
        else $error("second result missing or cursor changed");

endmodule

bind vt52_escape_command_decoder vt52ecd_checker u_vt52ecd_checker (.*);

// ----- tb/sv/vt52_escape_command_decoder_tb.sv -----
// ----------------------------------------------------------------------------
// VT52 escape command decoder testbench
// Streams escape bytes with random cursor positions into the decoder and
// checks every result transfer against a cycle-free predictor of the decoder.
// A short directed table walks most commands and the edge cases, then eight
// randomized phases sweep the limit registers and the idle/stall patterns.
// ----------------------------------------------------------------------------
module vt52_escape_command_decoder_tb;

    import vt52ecd_pkg::*;

    localparam int PHASE_ITEMS   = 230;
    localparam int NUM_PHASES    = 8;
    localparam int RUN_LIMIT     = 4_000_000;

    // One expected transfer on the result stream
    typedef struct packed {
        logic    last;
        t_result res;
    } screen_result_t;

    // One row of the directed table; typed rows carry a hand-written
    // action and cursor for a single-result byte
    typedef struct packed {
        logic [7:0] code;
        logic [7:0] col;
        logic [5:0] row;
        logic       typed;
        t_action    want_act;
        logic [7:0] want_col;
        logic [5:0] want_row;
    } directed_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [7:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // code_byte[7:0], cur_col[15:8], cur_row[21:16], zero
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // action[2:0], first_line[8:3], last_line[14:9],
                                 // column[22:15], new_col[30:23], new_row[36:31],
                                 // visible_flag[37], reverse_flag[38], wrap_flag[39]
    logic        m_axis_tlast;   // last

    // Predictor state, mirrors the decoder's registers
    t_phase      dec_phase     = PH_CMD;
    int          addr_row      = 0;
    int          saved_col_q   = 0;
    int          saved_row_q   = 0;
    logic        show_cursor   = 1'b0;
    logic        reverse_video = 1'b0;
    logic        line_wrap     = 1'b0;
    int          lim_col       = MAX_COL_RESET;
    int          lim_row       = MAX_ROW_RESET;

    screen_result_t pending_results[$];
    int             mismatch_count = 0;
    int             send_idle_pct  = 0;
    int             sink_stall_pct = 0;

    directed_row_t  dir_table[24];

    vt52_escape_command_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic t_act mk_act(input t_action kind, input int first, input int lastl,
                                    input int col);
        t_act a;
        a.action     = kind;
        a.first_line = 6'(first);
        a.last_line  = 6'(lastl);
        a.column     = 8'(col);
        return a;
    endfunction

    // Remove the bias of an addressing byte; anything below the bias
    // (or above 159) reads as negative and clamps to zero
    function automatic int unbias_param(input logic [7:0] b, input int limit);
        logic [7:0] v;
        v = b - PARAM_OFFSET;
        if (v[7]) begin
            v = 8'd0;
        end
        return (int'(v) < limit) ? int'(v) : limit;
    endfunction

    // Decode one accepted byte and queue every result it must produce
    function automatic void decode_escape(input logic [7:0] code, input logic [7:0] col_in,
                                          input logic [5:0] row_in);
        t_act           acts[$];
        int             x;
        int             y;
        screen_result_t entry;
        x = int'(col_in);
        y = int'(row_in);
        case (dec_phase)
            PH_ROW: begin
                addr_row  = unbias_param(code, lim_row);
                dec_phase = PH_COL;
            end
            PH_COL: begin
                x         = unbias_param(code, lim_col);
                y         = addr_row;
                dec_phase = PH_CMD;
            end
            default: begin
                dec_phase = PH_CMD;
                case (code)
                    CH_UP:    if (y > 0) y = y - 1;
                    CH_DOWN:  if (y < lim_row) y = y + 1;
                    CH_RIGHT: if (x < lim_col) x = x + 1;
                    CH_LEFT:  if (x > 0) x = x - 1;
                    CH_CLEAR: begin
                        acts.push_back(mk_act(ACT_CLEAR, 0, 0, 0));
                        x = 0;
                        y = 0;
                    end
                    CH_HOME: begin
                        x = 0;
                        y = 0;
                    end
                    CH_RUP: begin
                        if (y > 0) y = y - 1;
                        else acts.push_back(mk_act(ACT_SCROLL_DOWN, 0, lim_row, 0));
                    end
                    CH_CLR_EOS: begin
                        if (y + 1 <= lim_row)
                            acts.push_back(mk_act(ACT_CLR_LINES, y + 1, lim_row, 0));
                        acts.push_back(mk_act(ACT_ERASE_END, y, 0, x));
                    end
                    CH_CLR_EOL: acts.push_back(mk_act(ACT_ERASE_END, y, 0, x));
                    CH_INS, CH_DEL: begin
                        // on or below the last row the line just gets cleared
                        if (y >= lim_row)
                            acts.push_back(mk_act(ACT_CLR_LINES, y, y, 0));
                        else
                            acts.push_back(mk_act((code == CH_DEL) ? ACT_DELETE : ACT_INSERT,
                                                  y, lim_row, 0));
                        x = 0;
                    end
                    CH_ADDR:  dec_phase = PH_ROW;
                    CH_CLR_BOS: begin
                        if (y > 0) acts.push_back(mk_act(ACT_CLR_LINES, 0, y - 1, 0));
                        if (x > 0) acts.push_back(mk_act(ACT_ERASE_START, y, 0, x - 1));
                    end
                    CH_SHOW:  show_cursor = 1'b1;
                    CH_HIDE:  show_cursor = 1'b0;
                    CH_SAVE: begin
                        saved_col_q = x;
                        saved_row_q = y;
                    end
                    CH_RESTORE: begin
                        x = saved_col_q;
                        y = saved_row_q;
                    end
                    CH_CLR_LN: begin
                        acts.push_back(mk_act(ACT_CLR_LINES, y, y, 0));
                        x = 0;
                    end
                    CH_CLR_BOL:  acts.push_back(mk_act(ACT_ERASE_START, y, 0, x));
                    CH_REV_ON:   reverse_video = 1'b1;
                    CH_REV_OFF:  reverse_video = 1'b0;
                    CH_WRAP_ON:  line_wrap = 1'b1;
                    CH_WRAP_OFF: line_wrap = 1'b0;
                    default: ;
                endcase
            end
        endcase

        // every byte answers at least once, even with nothing to draw
        if (acts.size() == 0) acts.push_back(ACT_IDLE);

        foreach (acts[k]) begin
            entry.res.act          = acts[k];
            entry.res.new_col      = 8'(x);
            entry.res.new_row      = 6'(y);
            entry.res.visible_flag = show_cursor;
            entry.res.reverse_flag = reverse_video;
            entry.res.wrap_flag    = line_wrap;
            entry.last             = (k == acts.size() - 1);
            pending_results.push_back(entry);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Offer one byte: insert random idle cycles, hold tvalid until the
    // transfer, then predict. tvalid stays high after the transfer so that a
    // back-to-back byte needs no second assignment in the same step.
    task automatic send_byte(input logic [7:0] code, input logic [7:0] col,
                             input logic [5:0] row);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, row, col, code};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        decode_escape(code, col, row);
    endtask

    // Drop tvalid and hold off until every expected result has arrived
    task automatic drain_results(input int holdoff);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (holdoff) @(negedge i_clk);
    endtask

    task automatic write_limits(input int col_lim, input int row_lim);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_MAX_COL;
        i_cfg_data  <= 8'(col_lim);
        @(negedge i_clk);
        i_cfg_index <= CFG_MAX_ROW;
        i_cfg_data  <= 8'(row_lim);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        lim_col = col_lim;
        lim_row = row_lim;
    endtask

    function automatic logic [7:0] pick_command();
        case ($urandom_range(0, 22))
            0:  return CH_UP;
            1:  return CH_DOWN;
            2:  return CH_RIGHT;
            3:  return CH_LEFT;
            4:  return CH_CLEAR;
            5:  return CH_HOME;
            6:  return CH_RUP;
            7:  return CH_CLR_EOS;
            8:  return CH_CLR_EOL;
            9:  return CH_INS;
            10: return CH_DEL;
            11: return CH_ADDR;
            12: return CH_CLR_BOS;
            13: return CH_SHOW;
            14: return CH_HIDE;
            15: return CH_SAVE;
            16: return CH_RESTORE;
            17: return CH_CLR_LN;
            18: return CH_CLR_BOL;
            19: return CH_REV_ON;
            20: return CH_REV_OFF;
            21: return CH_WRAP_ON;
            default: return CH_WRAP_OFF;
        endcase
    endfunction

    // Cursor values lean on the edges and the configured limits
    function automatic logic [7:0] pick_col();
        case ($urandom_range(0, 4))
            0:       return 8'($urandom_range(0, 255));
            1:       return 8'(lim_col);
            2:       return 8'd0;
            default: return 8'($urandom_range(0, lim_col));
        endcase
    endfunction

    function automatic logic [5:0] pick_row();
        case ($urandom_range(0, 4))
            0:       return 6'($urandom_range(0, 63));
            1:       return 6'(lim_row);
            2:       return 6'd0;
            default: return 6'($urandom_range(0, lim_row));
        endcase
    endfunction

    // Addressing byte: mostly biased values around the limit, some raw bytes
    function automatic logic [7:0] pick_param(input int limit);
        if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
        return 8'(32 + $urandom_range(0, limit + 2));
    endfunction

    // ------------------------------------------------------------------------
    // Result sink: stall at random, compare each transfer in order
    // ------------------------------------------------------------------------

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    task automatic check_field(input string name, input int want, input int seen);
        if (want != seen) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, seen);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_monitor
        t_result        got;
        screen_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata);
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected: tdata %h", m_axis_tdata);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("action",       want.res.act.action,     got.act.action);
                check_field("first_line",   want.res.act.first_line, got.act.first_line);
                check_field("last_line",    want.res.act.last_line,  got.act.last_line);
                check_field("column",       want.res.act.column,     got.act.column);
                check_field("new_col",      want.res.new_col,        got.new_col);
                check_field("new_row",      want.res.new_row,        got.new_row);
                check_field("visible_flag", want.res.visible_flag,   got.visible_flag);
                check_field("reverse_flag", want.res.reverse_flag,   got.reverse_flag);
                check_field("wrap_flag",    want.res.wrap_flag,      got.wrap_flag);
                check_field("last",         want.last,               m_axis_tlast);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial begin
        int         sent;
        int         r;
        int         col_lim;
        int         row_lim;
        int         idx;
        logic       paused;

        // drive every input known from time zero
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_MAX_COL;
        i_cfg_data    = 8'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 24'd0;
        m_axis_tready = 1'b0;

        // Directed table, run at the reset limits (max column 79, max row 24).
        // Fields: code, col, row, typed, action, new col, new row.
        dir_table = '{
            '{CH_UP,       8'd0,   6'd0,  1'b1, ACT_NONE,        8'd0,   6'd0},  // top edge
            '{CH_DOWN,     8'd79,  6'd24, 1'b1, ACT_NONE,        8'd79,  6'd24}, // bottom edge
            '{CH_RIGHT,    8'd255, 6'd63, 1'b1, ACT_NONE,        8'd255, 6'd63}, // beyond limits
            '{CH_LEFT,     8'd0,   6'd5,  1'b1, ACT_NONE,        8'd0,   6'd5},  // left edge
            '{CH_CLEAR,    8'd40,  6'd10, 1'b1, ACT_CLEAR,       8'd0,   6'd0},
            '{CH_HOME,     8'd12,  6'd3,  1'b1, ACT_NONE,        8'd0,   6'd0},
            '{CH_RUP,      8'd7,   6'd0,  1'b1, ACT_SCROLL_DOWN, 8'd7,   6'd0},  // scroll at top
            '{CH_CLR_EOS,  8'd20,  6'd5,  1'b0, ACT_NONE,        8'd0,   6'd0},  // two results
            '{CH_CLR_EOS,  8'd20,  6'd24, 1'b0, ACT_NONE,        8'd0,   6'd0},  // last row
            '{CH_CLR_EOL,  8'd33,  6'd2,  1'b0, ACT_NONE,        8'd0,   6'd0},
            '{CH_INS,      8'd10,  6'd4,  1'b0, ACT_NONE,        8'd0,   6'd0},
            '{CH_DEL,      8'd10,  6'd24, 1'b0, ACT_NONE,        8'd0,   6'd0},  // delete at bottom
            '{CH_CLR_BOS,  8'd0,   6'd0,  1'b1, ACT_NONE,        8'd0,   6'd0},  // nothing to erase
            '{CH_CLR_BOS,  8'd15,  6'd6,  1'b0, ACT_NONE,        8'd0,   6'd0},
            '{CH_SHOW,     8'd1,   6'd1,  1'b0, ACT_NONE,        8'd0,   6'd0},
            '{CH_REV_ON,   8'd2,   6'd2,  1'b0, ACT_NONE,        8'd0,   6'd0},
            '{CH_WRAP_ON,  8'd3,   6'd3,  1'b0, ACT_NONE,        8'd0,   6'd0},
            '{CH_SAVE,     8'd17,  6'd8,  1'b0, ACT_NONE,        8'd0,   6'd0},
            '{CH_RESTORE,  8'd0,   6'd0,  1'b0, ACT_NONE,        8'd0,   6'd0},
            '{CH_CLR_LN,   8'd30,  6'd7,  1'b0, ACT_NONE,        8'd0,   6'd0},
            '{CH_CLR_BOL,  8'd255, 6'd63, 1'b0, ACT_NONE,        8'd0,   6'd0},
            '{CH_ADDR,     8'd5,   6'd5,  1'b1, ACT_NONE,        8'd5,   6'd5},
            '{8'h7F,       8'd3,   6'd3,  1'b1, ACT_NONE,        8'd3,   6'd3},  // row clamps
            '{8'h1F,       8'd9,   6'd9,  1'b1, ACT_NONE,        8'd0,   6'd24}  // negative col
        };

        // hold reset, then release on a falling edge
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_table[i]) begin
            send_byte(dir_table[i].code, dir_table[i].col, dir_table[i].row);
            if (dir_table[i].typed) begin
                // typed rows replace the predicted action and cursor
                idx = pending_results.size() - 1;
                pending_results[idx].res.act.action = dir_table[i].want_act;
                pending_results[idx].res.new_col    = dir_table[i].want_col;
                pending_results[idx].res.new_row    = dir_table[i].want_row;
            end
        end
        // an unknown byte is ignored
        send_byte(8'hFF, 8'd9, 6'd9);
        idx = pending_results.size() - 1;
        pending_results[idx].res.act.action = ACT_NONE;

        // Random phases: sweep the limits and cycle the idle patterns
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results(4);
            case (ph)
                0: begin col_lim = 255; row_lim = 63; end
                1: begin col_lim = 0;   row_lim = 0;  end
                2: begin col_lim = 1;   row_lim = 62; end
                3: begin col_lim = 255; row_lim = 0;  end
                4: begin col_lim = 0;   row_lim = 63; end
                5: begin col_lim = 79;  row_lim = 24; end
                default: begin
                    col_lim = $urandom_range(0, 255);
                    row_lim = $urandom_range(0, 63);
                end
            endcase
            write_limits(col_lim, row_lim);

            case (ph % 4)
                0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin send_idle_pct = 56; sink_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  sink_stall_pct = 56; end
                default: begin send_idle_pct = 8; sink_stall_pct = 8; end
            endcase

            sent   = 0;
            paused = 1'b0;
            while (sent < PHASE_ITEMS) begin
                // halfway through, stop sending until the output runs dry
                if (!paused && sent >= PHASE_ITEMS / 2) begin
                    drain_results(0);
                    paused = 1'b1;
                end
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    send_byte(pick_command(), pick_col(), pick_row());
                    sent += 1;
                end else if (r < 85) begin
                    // well-formed direct addressing sequence
                    send_byte(CH_ADDR, pick_col(), pick_row());
                    send_byte(pick_param(lim_row), pick_col(), pick_row());
                    send_byte(pick_param(lim_col), pick_col(), pick_row());
                    sent += 3;
                end else begin
                    send_byte(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              6'($urandom_range(0, 63)));
                    sent += 1;
                end
            end
        end

        // let the tail drain, then give the pipeline time to misbehave
        drain_results(20);

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure
    initial begin
        #(RUN_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- vt52_escape_command_decoder.f -----
design/vt52ecd_pkg.sv
design/vt52ecd_front.sv
design/vt52ecd_queue.sv
design/vt52ecd_back.sv
design/vt52_escape_command_decoder.sv
design/vt52ecd_checker.sv
tb/sv/vt52_escape_command_decoder_tb.sv
